@@ hw/rtl/asl_pkg.sv @@
// ----------------------------------------------------------------------------
// asl_pkg
// Shared types, constants and helper functions for the averaging sample
// logger: input kinds, command bytes, FIFO sizing, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package asl_pkg;

  localparam int FIFO_DEPTH          = 64;
  localparam int SAMPLES_PER_AVERAGE = 16;

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam int SCNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int SUM_W  = 10 + $clog2(SAMPLES_PER_AVERAGE + 1);

  localparam int SAMPLE_W = 10;
  localparam int VALUE_W  = 7;
  localparam int PROD_W   = 17;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_CMD    = 2'd2;

  localparam logic [7:0] CMD_START = 8'd82;  // 'R'
  localparam logic [7:0] CMD_DUMP  = 8'd76;  // 'L'

  localparam logic [7:0]         PERIOD_RESET = 8'd25;
  localparam logic [6:0]         SCALE_MAX    = 7'd70;
  localparam logic [PROD_W-1:0]  SCALE_ROUND  = PROD_W'(511);
  localparam logic [10:0]        SCALE_DIV    = 11'd1023;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_LIVE,
    S_RD,
    S_EMIT
  } asl_state_t;

  typedef struct packed {
    logic accept;    // take the input beat
    logic mul;       // scale the closed average
    logic div;       // reduce the scaled product by 1023
    logic ld_live;   // load the live value into the output register
    logic rd;        // read the FIFO head
    logic ld_drain;  // load the drained value into the output register
  } asl_cmd_t;

  typedef struct packed {
    logic avg_done;   // sample beat closes an average
    logic log_tick;   // tick beat logs a value
    logic dump_data;  // dump command with entries stored
    logic fifo_data;  // entries still stored
    logic out_free;   // output register can take a beat
  } asl_stat_t;

  // Tens digit of a value below 80, by reciprocal multiply.
  function automatic logic [2:0] tens_of(input logic [VALUE_W-1:0] v);
    logic [14:0] p;
    p = {8'd0, v} * 15'd205;
    return p[13:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [VALUE_W-1:0] v);
    logic [2:0] t;
    logic [6:0] tt;
    t  = tens_of(v);
    tt = {4'd0, t} * 7'd10;
    return 4'(v - tt);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/asl_ctrl.sv @@
// ----------------------------------------------------------------------------
// asl_ctrl
// Controller state machine: takes input beats, sequences the average
// scaling, the live output and the FIFO drain.
// ----------------------------------------------------------------------------
`default_nettype none

module asl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire asl_pkg::asl_stat_t st,
  output asl_pkg::asl_cmd_t      cmd
);

  asl_pkg::asl_state_t state;
  asl_pkg::asl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      asl_pkg::S_IDLE: begin
        if (in_valid) begin
          priority if (st.avg_done)  state_next = asl_pkg::S_MUL;
          else if (st.log_tick)      state_next = asl_pkg::S_LIVE;
          else if (st.dump_data)     state_next = asl_pkg::S_RD;
          else                       state_next = asl_pkg::S_IDLE;
        end
      end
      asl_pkg::S_MUL:  state_next = asl_pkg::S_DIV;
      asl_pkg::S_DIV:  state_next = asl_pkg::S_IDLE;
      asl_pkg::S_LIVE: begin
        if (st.out_free) state_next = asl_pkg::S_IDLE;
      end
      asl_pkg::S_RD:   state_next = asl_pkg::S_EMIT;
      asl_pkg::S_EMIT: begin
        // fifo_data already reflects the entry taken in S_RD
        if (st.out_free) state_next = st.fifo_data ? asl_pkg::S_RD : asl_pkg::S_IDLE;
      end
      default:         state_next = asl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      asl_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      asl_pkg::S_MUL:  cmd.mul      = 1'b1;
      asl_pkg::S_DIV:  cmd.div      = 1'b1;
      asl_pkg::S_LIVE: cmd.ld_live  = st.out_free;
      asl_pkg::S_RD:   cmd.rd       = 1'b1;
      asl_pkg::S_EMIT: cmd.ld_drain = st.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/asl_dp.sv @@
// ----------------------------------------------------------------------------
// asl_dp
// Datapath: sample accumulator and scaler, tick counter, period register,
// ring FIFO memory with pointers and fill count, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module asl_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [1:0]           kind,
  input  wire logic [9:0]           sample,
  input  wire logic [7:0]           byte_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [7:0]           ticks_per_log,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic                      origin,
  output logic [2:0]                tens_digit,
  output logic [3:0]                ones_digit,
  output logic                      last,
  output logic                      dropped,
  input  wire asl_pkg::asl_cmd_t    cmd,
  output asl_pkg::asl_stat_t        st
);

  logic [7:0]                    period;
  logic                          running;
  logic [7:0]                    tick_count;
  logic [asl_pkg::SUM_W-1:0]     sample_sum;
  logic [asl_pkg::SCNT_W-1:0]    sample_count;
  logic [asl_pkg::SAMPLE_W-1:0]  avg;
  logic [asl_pkg::PROD_W-1:0]    prod;
  logic [asl_pkg::VALUE_W-1:0]   average_value;
  logic [asl_pkg::VALUE_W-1:0]   mem [asl_pkg::FIFO_DEPTH];
  logic [asl_pkg::VALUE_W-1:0]   rd_data;
  logic [asl_pkg::PTR_W-1:0]     read_pointer;
  logic [asl_pkg::PTR_W-1:0]     write_pointer;
  logic [asl_pkg::FILL_W-1:0]    fill_count;
  logic                          drain_last;
  logic                          drop_flag;

  logic [asl_pkg::SUM_W-1:0]     sum_next;
  logic [asl_pkg::SCNT_W-1:0]    count_next;
  logic [7:0]                    tick_inc;
  logic                          fifo_full;
  logic                          is_sample;
  logic                          is_tick;
  logic                          is_start;
  logic                          is_dump;
  logic                          push;
  logic [6:0]                    q0;
  logic [10:0]                   rem;
  logic [asl_pkg::VALUE_W-1:0]   out_value;

  assign cfg_ready = 1'b1;

  assign sum_next   = sample_sum + asl_pkg::SUM_W'(sample);
  assign count_next = sample_count + asl_pkg::SCNT_W'(1);
  assign tick_inc   = tick_count + 8'd1;
  assign fifo_full  = (fill_count == asl_pkg::FILL_W'(asl_pkg::FIFO_DEPTH));

  assign is_sample = (kind == asl_pkg::KIND_SAMPLE);
  assign is_tick   = (kind == asl_pkg::KIND_TICK);
  assign is_start  = (kind == asl_pkg::KIND_CMD) && (byte_value == asl_pkg::CMD_START);
  assign is_dump   = (kind == asl_pkg::KIND_CMD) && (byte_value == asl_pkg::CMD_DUMP);

  assign st.avg_done  = is_sample &&
                        (count_next == asl_pkg::SCNT_W'(asl_pkg::SAMPLES_PER_AVERAGE));
  assign st.log_tick  = is_tick && running && (tick_inc >= period);
  assign st.dump_data = is_dump && (fill_count != '0);
  assign st.fifo_data = (fill_count != '0);
  assign st.out_free  = !out_valid || !out_stall;

  assign push = cmd.accept && st.log_tick && !fifo_full;

  // prod = q0*1024 + lo = q0*1023 + (q0 + lo), and q0 + lo < 2*1023
  assign q0  = prod[16:10];
  assign rem = {4'd0, q0} + {1'b0, prod[9:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= asl_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      period <= ticks_per_log;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      tick_count    <= '0;
      sample_sum    <= '0;
      sample_count  <= '0;
      average_value <= '0;
      read_pointer  <= '0;
      write_pointer <= '0;
      fill_count    <= '0;
    end else begin
      if (cmd.accept) begin
        if (is_sample) begin
          if (st.avg_done) begin
            sample_sum   <= '0;
            sample_count <= '0;
          end else begin
            sample_sum   <= sum_next;
            sample_count <= count_next;
          end
        end
        if (is_tick && running) begin
          tick_count <= st.log_tick ? 8'd0 : tick_inc;
        end
        if (is_start) running <= 1'b1;
        if (is_dump)  running <= 1'b0;
        if (push) begin
          write_pointer <= (write_pointer == asl_pkg::PTR_W'(asl_pkg::FIFO_DEPTH - 1))
                           ? '0 : write_pointer + asl_pkg::PTR_W'(1);
          fill_count    <= fill_count + asl_pkg::FILL_W'(1);
        end
      end
      if (cmd.div) begin
        average_value <= (rem >= asl_pkg::SCALE_DIV) ? q0 + 7'd1 : q0;
      end
      if (cmd.rd) begin
        read_pointer <= (read_pointer == asl_pkg::PTR_W'(asl_pkg::FIFO_DEPTH - 1))
                        ? '0 : read_pointer + asl_pkg::PTR_W'(1);
        fill_count   <= fill_count - asl_pkg::FILL_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && st.avg_done) begin
      avg <= asl_pkg::SAMPLE_W'(sum_next / asl_pkg::SAMPLES_PER_AVERAGE);
    end
    if (cmd.mul) begin
      prod <= asl_pkg::PROD_W'(avg) * asl_pkg::PROD_W'(asl_pkg::SCALE_MAX)
              + asl_pkg::SCALE_ROUND;
    end
    if (cmd.accept && st.log_tick) begin
      drop_flag <= fifo_full;
    end
    if (cmd.rd) begin
      drain_last <= (fill_count == asl_pkg::FILL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[write_pointer] <= average_value;
    end
    if (cmd.rd) begin
      rd_data <= mem[read_pointer];
    end
  end

  assign out_value = cmd.ld_drain ? rd_data : average_value;

  // Output register: hold while stalled, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_live || cmd.ld_drain) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_live || cmd.ld_drain) begin
      origin     <= cmd.ld_drain;
      tens_digit <= asl_pkg::tens_of(out_value);
      ones_digit <= asl_pkg::ones_of(out_value);
      last       <= cmd.ld_drain ? drain_last : 1'b1;
      dropped    <= cmd.ld_drain ? 1'b0 : drop_flag;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/averaging_sample_logger_fifo.sv @@
// ----------------------------------------------------------------------------
// averaging_sample_logger_fifo
// Converter averaging logger with a ring FIFO of logged values.
// ----------------------------------------------------------------------------
// A sample beat is taken in S_IDLE; when it closes an average, S_MUL
// multiplies it by 70 and S_DIV reduces the product by 1023. A tick beat
// that logs a value goes on to S_LIVE, which loads the live result. A dump
// command walks the FIFO through S_RD and S_EMIT for each stored entry,
// as the FIFO memory has a registered read port; a full FIFO holds 64
// entries. The output register lets a result wait while the next beat is
// taken. The FIFO memory needs no clearing after reset, so the block takes
// beats right away.
`default_nettype none

module averaging_sample_logger_fifo (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] kind,
  input  wire logic [9:0] sample,
  input  wire logic [7:0] byte_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            origin,
  output logic [2:0]      tens_digit,
  output logic [3:0]      ones_digit,
  output logic            last,
  output logic            dropped,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] ticks_per_log
);

  asl_pkg::asl_cmd_t  cmd;
  asl_pkg::asl_stat_t st;

  asl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  asl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .kind          (kind),
    .sample        (sample),
    .byte_value    (byte_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .ticks_per_log (ticks_per_log),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .origin        (origin),
    .tens_digit    (tens_digit),
    .ones_digit    (ones_digit),
    .last          (last),
    .dropped       (dropped),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

`default_nettype wire

@@ hw/rtl/asl_checker.sv @@
// ----------------------------------------------------------------------------
// asl_checker
// Port-level checks on the logger's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module asl_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] kind,
  input wire logic [9:0] sample,
  input wire logic [7:0] byte_value,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       origin,
  input wire logic [2:0] tens_digit,
  input wire logic [3:0] ones_digit,
  input wire logic       last,
  input wire logic       dropped,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic [7:0] ticks_per_log
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(origin) && $stable(tens_digit)
      && $stable(ones_digit) && $stable(last) && $stable(dropped))
    else $error("stalled result beat changed");

  // A live value is always the only result of its tick
  a_live_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !origin |-> last)
    else $error("live result without last mark");

  a_drain_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && origin |-> !dropped)
    else $error("drained result flagged as dropped");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ones_digit <= 4'd9) && (tens_digit <= 3'd7))
    else $error("decimal digit out of range");

endmodule

bind averaging_sample_logger_fifo asl_checker u_asl_checker (.*);

`default_nettype wire
